### hdl/ftp_pkg.sv
// shared types and constants for the frustum test and projection block
`timescale 1ns / 1ps
`default_nettype none
package ftp_pkg;
    localparam int COORD_FRAC_BITS = 16;
    localparam int QW = 48;                  // numerator width, 15 x 33 bits
    localparam int DW = 32;                  // divisor width (|z| fits 32 bits)
    localparam int NCELL = QW;               // one quotient bit per cell
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HALF_W  = 3'd0,
        REG_HALF_H  = 3'd1,
        REG_ASPECT  = 3'd2,
        REG_NEAR    = 3'd3,
        REG_FAR     = 3'd4
    } t_reg_idx;

    // per-item data riding along the cell row
    typedef struct packed {
        logic          vld;
        logic          visible;
        logic          neg_x;
        logic          neg_y;
        logic [14:0]   half_w;
        logic [14:0]   half_h;
        logic [QW-1:0] num_x;   // shifts out high bits while quotient shifts in
        logic [QW-1:0] num_y;
        logic [DW:0]   rem_x;
        logic [DW:0]   rem_y;
        logic [DW-1:0] den;
    } t_cell;
endpackage
`default_nettype wire

### hdl/ftp_div_cell.sv
// one restoring-division cell: one quotient bit per axis, registered
`timescale 1ns / 1ps
`default_nettype none
module ftp_div_cell (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire ftp_pkg::t_cell  i_cell,
    output ftp_pkg::t_cell       o_cell
);
    import ftp_pkg::*;

    t_cell       r_cell;
    t_cell       n_cell;
    logic [DW:0] w_tx;
    logic [DW:0] w_ty;
    logic [DW:0] w_dx;
    logic [DW:0] w_dy;

    always_comb begin
        n_cell = i_cell;
        w_tx = {i_cell.rem_x[DW-1:0], i_cell.num_x[QW-1]};
        w_ty = {i_cell.rem_y[DW-1:0], i_cell.num_y[QW-1]};
        w_dx = w_tx - {1'b0, i_cell.den};
        w_dy = w_ty - {1'b0, i_cell.den};
        n_cell.rem_x = w_dx[DW] ? w_tx : w_dx;
        n_cell.rem_y = w_dy[DW] ? w_ty : w_dy;
        n_cell.num_x = {i_cell.num_x[QW-2:0], ~w_dx[DW]};
        n_cell.num_y = {i_cell.num_y[QW-2:0], ~w_dy[DW]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.vld <= 1'b0;
        end else if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;
endmodule
`default_nettype wire

### hdl/frustum_test_and_project.sv
// top level: frustum test, multiply stage, divider cell row, output stage
//
// channel   dir  tdata fields (low bit up)              tuser
// s_axis    in   view_x[31:0] view_y[63:32] view_z[95:64]  -
// m_axis    out  pixel_x[15:0] pixel_y[31:16]           inside_res
// cfg       in   i_cfg_we, i_cfg_idx, i_cfg_data
//
// one vertex per cycle unless the output stalls; registers are the test/abs register and 48 divider cells
// the multiply and vertical test feed the first cell without a register of their own
// the whole row advances together, so m_axis_tready low while m_axis_tvalid is high stalls every stage
// s_axis_tready is high whenever the last cell can move on
// synchronous active-low reset empties the row and loads register defaults
`timescale 1ns / 1ps
`default_nettype none
module frustum_test_and_project (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [ftp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [ftp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           s_axis_tvalid,
    output      logic                           s_axis_tready,
    input  wire logic [95:0]                    s_axis_tdata,  // view_x, view_y, view_z
    output      logic                           m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output      logic [31:0]                    m_axis_tdata,  // pixel_x, pixel_y
    output      logic                           m_axis_tuser   // inside_res
);
    import ftp_pkg::*;

    logic [14:0] r_half_w, r_half_h;
    logic [15:0] r_aspect;
    logic signed [31:0] r_near, r_far;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_w <= 15'd160;
            r_half_h <= 15'd120;
            r_aspect <= 16'd341;
            r_near   <= 32'sd65536;
            r_far    <= 32'sd65536000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_HALF_W: r_half_w <= i_cfg_data[14:0];
                REG_HALF_H: r_half_h <= i_cfg_data[14:0];
                REG_ASPECT: r_aspect <= i_cfg_data[15:0];
                REG_NEAR:   r_near   <= i_cfg_data;
                REG_FAR:    r_far    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic w_en;
    t_cell w_row [NCELL+1];
    t_cell w_head;

    assign w_en = !w_row[NCELL].vld || m_axis_tready;
    assign s_axis_tready = w_en;

    // stage 1: frustum compare and magnitudes
    logic signed [31:0] w_x, w_y, w_z;
    logic [32:0] w_ax, w_ay, w_az;
    logic        w_inside;
    assign w_x = s_axis_tdata[31:0];
    assign w_y = s_axis_tdata[63:32];
    assign w_z = s_axis_tdata[95:64];
    assign w_ax = w_x[31] ? 33'd0 - {w_x[31], w_x} : {1'b0, w_x};
    assign w_ay = w_y[31] ? 33'd0 - {w_y[31], w_y} : {1'b0, w_y};
    assign w_az = w_z[31] ? 33'd0 - {w_z[31], w_z} : {1'b0, w_z};
    assign w_inside = (w_z > r_near) && (w_z < r_far) && (w_az > w_ax);

    logic        r1_vld, r1_in, r1_nx, r1_ny;
    logic [32:0] r1_ay, r1_az, r1_ax;
    logic [14:0] r1_hw, r1_hh;
    logic [15:0] r1_asp;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (w_en) begin
            r1_vld <= s_axis_tvalid;
        end
        if (w_en) begin
            r1_in <= w_inside;
            r1_nx <= w_x[31] ^ w_z[31];
            r1_ny <= w_y[31] ^ w_z[31];
            r1_ax <= w_ax;
            r1_ay <= w_ay;
            r1_az <= w_az;
            r1_hw <= r_half_w;
            r1_hh <= r_half_h;
            r1_asp <= r_aspect;
        end
    end

    // stage 2: multiplies and vertical test
    logic [48:0] w_ym;
    logic [40:0] w_zs;
    logic [QW-1:0] w_mx;
    logic [QW-1:0] w_my;
    assign w_ym = r1_ay * r1_asp;
    assign w_zs = {r1_az, 8'd0};
    assign w_mx = r1_ax * r1_hw;
    assign w_my = r1_ay * r1_hw;
    always_comb begin
        w_head.vld     = r1_vld;
        w_head.visible = r1_in && ({8'd0, w_zs} > w_ym);
        w_head.neg_x   = r1_nx;
        w_head.neg_y   = r1_ny;
        w_head.half_w  = r1_hw;
        w_head.half_h  = r1_hh;
        w_head.num_x   = w_mx;
        w_head.num_y   = w_my;
        w_head.rem_x   = '0;
        w_head.rem_y   = '0;
        w_head.den     = r1_az[DW-1:0];
    end
    assign w_row[0] = w_head;

    genvar g;
    generate
        for (g = 0; g < NCELL; g++) begin : g_cell
            ftp_div_cell u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_en   (w_en),
                .i_cell (w_row[g]),
                .o_cell (w_row[g+1])
            );
        end
    endgenerate

    // output: offset and saturate
    function automatic logic [15:0] f_place(input logic [14:0] c, input logic [QW-1:0] q,
                                             input logic neg);
        logic [QW:0] s;
        s = {1'b0, q};
        if (neg) begin
            f_place = (q > QW'(c)) ? 16'd0 : 16'(c - q[14:0]);
        end else begin
            s = s + (QW+1)'(c);
            f_place = (s > (QW+1)'(16'hFFFF)) ? 16'hFFFF : s[15:0];
        end
    endfunction

    t_cell w_o;
    assign w_o = w_row[NCELL];
    assign m_axis_tvalid = w_o.vld;
    assign m_axis_tuser  = w_o.visible;
    assign m_axis_tdata  = w_o.visible ?
        {f_place(w_o.half_h, w_o.num_y, w_o.neg_y), f_place(w_o.half_w, w_o.num_x, w_o.neg_x)}
        : 32'd0;
endmodule
`default_nettype wire

### hdl/ftp_checker.sv
// port-level checks for the frustum block, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module ftp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic        m_axis_tuser
);
    a_out_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == 32'd0)) else $error("outside not zero");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready) else $error("ready dropped");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled output changed");
    a_empty: assert property (@(posedge i_clk) !$past(i_rst_n) |-> !m_axis_tvalid)
        else $error("valid after reset");
endmodule

bind frustum_test_and_project ftp_checker u_chk (.*);
`default_nettype wire
